// File: design/tspsa_pkg.sv
// Shared constants, types and register codes for the packet sync aligner.
`default_nettype none
package tspsa_pkg;

  localparam int PACKET_BYTES = 188;
  localparam int MAX_MATCH    = 4;
  localparam int DELAY_DEPTH  = (MAX_MATCH - 1) * PACKET_BYTES + 1;

  localparam int ADDR_W = $clog2(PACKET_BYTES);
  localparam int POS_W  = $clog2(PACKET_BYTES);
  localparam int FILL_W = $clog2(DELAY_DEPTH);
  localparam int NEED_W = $clog2(MAX_MATCH + 1);

  localparam int SKIP_W  = 12;
  localparam int MATCH_W = 3;
  localparam int CFG_W   = 12;
  localparam int IDX_W   = 2;

  localparam logic [SKIP_W-1:0] DROP_MAX = {SKIP_W{1'b1}};

  // One RAM row holds the bytes one, two, ... packet lengths back.
  typedef logic [MAX_MATCH-2:0][7:0] row_t;
  // Tap 0 is the newest byte, the top tap is the byte leaving the line.
  typedef logic [MAX_MATCH-1:0][7:0] taps_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SYNC_VALUE   = 2'd0,
    REG_MATCH_COUNT  = 2'd1,
    REG_SEARCH_LIMIT = 2'd2
  } reg_index_t;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [7:0]        data;
    logic              start;
    logic              last;
    logic [SKIP_W-1:0] skipped;
  } res_t;

  typedef struct packed {
    logic [7:0]         sync_value;
    logic [MATCH_W-1:0] match_count;
    logic [SKIP_W-1:0]  search_limit;
  } cfg_t;

endpackage
`default_nettype wire

// File: design/ts_packet_sync_aligner_unit.sv
// Top level of the packet sync aligner: config registers, pipeline and output register.
`default_nettype none
// Packet sync aligner. Takes one stream byte per clock and, once locked,
// hands out aligned packet bytes with start and end marks; while hunting it
// drops bytes and, after search_limit drops, gives a sync-not-found status
// (kind 1, out_byte 0, skipped = drop count) and carries on hunting. A lock
// needs match_count sync bytes spaced one packet apart, so each byte is held
// back by (MAX_MATCH-1) packet lengths: the first 564 requests give
// no result, and every request after that gives at most one. Sustained rate
// is one request per clock while no result is held by out_stall; a request
// has its RAM row read, then is decided, and its result is registered in the
// output register. The history lives in a single RAM of
// PACKET_BYTES rows, each row holding the bytes one, two and three packet
// lengths back for one byte slot; the row is read when a byte is taken and
// written back, shifted by one packet, when that byte is decided. A row is
// revisited only after a full packet of requests, so read and write-back never
// collide. in_stall rises only while a result waits in the output register
// under out_stall and the decision stage is occupied. No clearing pass is
// needed after reset: no result is given before the RAM has been filled.
module ts_packet_sync_aligner_unit
  import tspsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        data_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   kind,
  output logic [7:0]             out_byte,
  output logic                   packet_start,
  output logic                   packet_end,
  output logic [SKIP_W-1:0]      skipped
);

  cfg_t cfg;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value   <= 8'd71;
      cfg.match_count  <= MATCH_W'(4);
      cfg.search_limit <= SKIP_W'(564);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_VALUE:   cfg.sync_value   <= cfg_data[7:0];
        REG_MATCH_COUNT:  cfg.match_count  <= cfg_data[MATCH_W-1:0];
        REG_SEARCH_LIMIT: cfg.search_limit <= cfg_data[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 0: take the request and start the row read.
  // Stage 1: row data is back; decide, write the shifted row back.
  logic              accept;
  logic              s1_valid;
  logic              s1_go;
  logic              fire;
  logic [7:0]        s1_byte;
  logic [ADDR_W-1:0] s1_addr;
  logic [ADDR_W-1:0] ptr;
  row_t              rd_row;
  taps_t             taps;
  res_t              res;

  assign s1_go    = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_go;
  assign accept   = in_valid && !in_stall;
  assign fire     = s1_valid && s1_go;
  assign taps     = taps_t'({rd_row, s1_byte});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      ptr      <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        ptr      <= (ptr == ADDR_W'(PACKET_BYTES - 1)) ? '0 : ptr + ADDR_W'(1);
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Hold the stage-1 payload alongside its row address.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= data_byte;
      s1_addr <= ptr;
    end
  end

  tspsa_delay_ram u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (ptr),
    .rd_data (rd_row),
    .wr_en   (fire),
    .wr_addr (s1_addr),
    .wr_data (taps[MAX_MATCH-2:0])
  );

  tspsa_lock_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .taps (taps),
    .cfg  (cfg),
    .res  (res)
  );

  // Output register: load on a new result, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      kind         <= res.kind;
      out_byte     <= res.data;
      packet_start <= res.start;
      packet_end   <= res.last;
      skipped      <= res.skipped;
    end
  end

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_result_from_fire : assert property (@(posedge clk) disable iff (rst)
    res.valid |-> fire)
    else $error("result raised outside a decision cycle");

  a_status_format : assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_STATUS) |->
      (out_byte == 8'd0 && !packet_start && !packet_end && skipped != '0))
    else $error("malformed not-found status");

  a_held_result : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(skipped) && $stable(out_byte)))
    else $error("waiting result overwritten");

endmodule
`default_nettype wire

// File: design/tspsa_delay_ram.sv
// Delay RAM: one row per byte slot of a packet, registered read.
`default_nettype none
module tspsa_delay_ram
  import tspsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output row_t                   rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire row_t              wr_data
);

  row_t mem [PACKET_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: design/tspsa_lock_fsm.sv
// Hunt/lock controller: fill tracking, sync check, packet position and drop count.
`default_nettype none
module tspsa_lock_fsm
  import tspsa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  fire,
  input  wire taps_t taps,
  input  wire cfg_t  cfg,
  output res_t       res
);

  typedef enum logic {ST_HUNT, ST_LOCK} state_t;

  state_t            state, state_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [SKIP_W-1:0] drop, drop_next;

  logic [NEED_W-1:0] need;
  logic [SKIP_W-1:0] lim;
  logic [SKIP_W-1:0] drop_base;
  logic [SKIP_W-1:0] drop_inc;
  logic [7:0]        head;
  logic              full;
  logic              match;
  logic              lost;

  always_comb begin
    head = taps[MAX_MATCH-1];
    full = (fill == FILL_W'(DELAY_DEPTH - 1));

    if (cfg.match_count == '0) begin
      need = NEED_W'(1);
    end else if (int'(cfg.match_count) > MAX_MATCH) begin
      need = NEED_W'(MAX_MATCH);
    end else begin
      need = NEED_W'(cfg.match_count);
    end

    match = 1'b1;
    for (int n = 0; n < MAX_MATCH; n++) begin
      if (NEED_W'(n) < need && taps[MAX_MATCH-1-n] != cfg.sync_value) begin
        match = 1'b0;
      end
    end

    lim = (cfg.search_limit == '0) ? SKIP_W'(1) : cfg.search_limit;
    lost = (state == ST_LOCK) && (pos == '0) && (head != cfg.sync_value);
    drop_base = lost ? '0 : drop;
    drop_inc = (drop_base == DROP_MAX) ? drop_base : drop_base + SKIP_W'(1);

    state_next = state;
    fill_next  = fill;
    pos_next   = pos;
    drop_next  = drop;
    res        = '0;

    if (fire) begin
      if (!full) begin
        fill_next = fill + FILL_W'(1);
      end else if (state == ST_LOCK && !lost) begin
        res.valid   = 1'b1;
        res.kind    = KIND_PACKET;
        res.data    = head;
        res.start   = (pos == '0);
        res.last    = (pos == POS_W'(PACKET_BYTES - 1));
        res.skipped = res.start ? drop : '0;
        if (res.start) begin
          drop_next = '0;
        end
        pos_next = res.last ? '0 : pos + POS_W'(1);
      end else if (match) begin
        // Lock here: this byte opens the first aligned packet.
        state_next  = ST_LOCK;
        res.valid   = 1'b1;
        res.kind    = KIND_PACKET;
        res.data    = head;
        res.start   = 1'b1;
        res.last    = (PACKET_BYTES == 1);
        res.skipped = drop_base;
        drop_next   = '0;
        pos_next    = (PACKET_BYTES == 1) ? '0 : POS_W'(1);
      end else begin
        // Drop the byte; a lost packet start counts as the first drop.
        state_next = ST_HUNT;
        if (drop_inc >= lim) begin
          res.valid   = 1'b1;
          res.kind    = KIND_STATUS;
          res.skipped = drop_inc;
          drop_next   = '0;
        end else begin
          drop_next = drop_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
      fill  <= '0;
      pos   <= '0;
      drop  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      pos   <= pos_next;
      drop  <= drop_next;
    end
  end

endmodule
`default_nettype wire
